/* rtl/dual_hash_bucket_occupancy_defines.svh */
// Assertion macros for the dual-hash bucket occupancy block.
// Used by files that assert; they need clk_i and rst_ni in scope.
`ifndef DUAL_HASH_BUCKET_OCCUPANCY_DEFINES_SVH
`define DUAL_HASH_BUCKET_OCCUPANCY_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define DHBO_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define DHBO_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/dhbo_pkg.sv */
// Shared types and constants of the dual-hash bucket occupancy block.
// No dependencies; the interfaces, controller, datapath and top import it.
package dhbo_pkg;

  localparam int CHAR_W      = 8;
  localparam int BYTE_VALUES = 256;
  localparam int IDX_W       = 7;
  localparam int CNT_W       = 7;
  localparam int TOT_W       = 32;
  localparam int KEY_W       = 32;
  localparam int MULT_W      = 32;
  localparam int OCC_W       = 2;

  localparam logic [KEY_W-1:0]  POLY_BASE  = 32'd31;
  localparam logic [MULT_W-1:0] MULT_RESET = 32'd2654431522;

  // Saturating occupancy codes of one bucket.
  localparam logic [OCC_W-1:0] OCC_EMPTY  = 2'd0;
  localparam logic [OCC_W-1:0] OCC_SINGLE = 2'd1;
  localparam logic [OCC_W-1:0] OCC_MULTI  = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MUL   = 5'b00010,
    ST_SCALE = 5'b00100,
    ST_READ  = 5'b01000,
    ST_WRITE = 5'b10000
  } dhbo_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic acc_char;  // a byte that does not end the word
    logic word_end;  // the last byte of a word
    logic mul_en;    // form the 0.32 fraction
    logic scale_en;  // scale the fraction to a bucket index
    logic rd_en;     // read both occupancy tables
    logic wr_en;     // update tables and counters, load the result
  } dhbo_cmd_t;

endpackage

/* rtl/dhbo_if.sv */
// Handshake interfaces of the dual-hash bucket occupancy block.
// Depends on dhbo_pkg for the field widths.
interface dhbo_in_if import dhbo_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last_char;

  modport source (output valid, char_code, last_char, input ready);
  modport sink (input valid, char_code, last_char, output ready);
endinterface

interface dhbo_out_if import dhbo_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] sum_index;
  logic [IDX_W-1:0] mult_index;
  logic             sum_collision;
  logic             mult_collision;
  logic [TOT_W-1:0] sum_collisions_total;
  logic [TOT_W-1:0] mult_collisions_total;
  logic [CNT_W-1:0] sum_empty;
  logic [CNT_W-1:0] sum_single;
  logic [CNT_W-1:0] sum_multi;
  logic [CNT_W-1:0] mult_empty;
  logic [CNT_W-1:0] mult_single;
  logic [CNT_W-1:0] mult_multi;

  modport source (
    output valid, sum_index, mult_index, sum_collision, mult_collision,
           sum_collisions_total, mult_collisions_total, sum_empty, sum_single,
           sum_multi, mult_empty, mult_single, mult_multi,
    input  ready
  );
  modport sink (
    input  valid, sum_index, mult_index, sum_collision, mult_collision,
           sum_collisions_total, mult_collisions_total, sum_empty, sum_single,
           sum_multi, mult_empty, mult_single, mult_multi,
    output ready
  );
endinterface

/* rtl/dhbo_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dhbo_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 127
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/dhbo_ctrl.sv */
// Controller of the dual-hash bucket occupancy block: sequences word ends
// and owns both handshakes. Depends on dhbo_pkg.
module dhbo_ctrl import dhbo_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_last_i,
  input  logic      out_ready_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  output dhbo_cmd_t cmd_o
);

  dhbo_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        in_acc;
  logic        out_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  // The result register can take a new result when it is empty or drains now.
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.acc_char = in_acc && !in_last_i;
    cmd_o.word_end = in_acc && in_last_i;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.word_end) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.scale_en = 1'b1;
        state_d        = ST_READ;
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_WRITE;
      end
      ST_WRITE: begin
        if (out_free) begin
          cmd_o.wr_en = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.wr_en) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* rtl/dhbo_datapath.sv */
// Datapath of the dual-hash bucket occupancy block: hash accumulators,
// multiplicative index, occupancy tables and counters. Depends on dhbo_pkg
// and dhbo_ram.
module dhbo_datapath import dhbo_pkg::*; #(
  parameter int TABLE_SIZE = 127
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dhbo_cmd_t         cmd_i,
  input  logic              cfg_we_i,
  input  logic [MULT_W-1:0] cfg_data_i,
  input  logic [CHAR_W-1:0] char_code_i,
  output logic [IDX_W-1:0]  sum_index_o,
  output logic [IDX_W-1:0]  mult_index_o,
  output logic              sum_collision_o,
  output logic              mult_collision_o,
  output logic [TOT_W-1:0]  sum_collisions_total_o,
  output logic [TOT_W-1:0]  mult_collisions_total_o,
  output logic [CNT_W-1:0]  sum_empty_o,
  output logic [CNT_W-1:0]  sum_single_o,
  output logic [CNT_W-1:0]  sum_multi_o,
  output logic [CNT_W-1:0]  mult_empty_o,
  output logic [CNT_W-1:0]  mult_single_o,
  output logic [CNT_W-1:0]  mult_multi_o
);

  localparam int               ADDR_W = $clog2(TABLE_SIZE);
  localparam logic [IDX_W-1:0] TS_C   = IDX_W'(TABLE_SIZE);
  localparam int               PROD_W = MULT_W + IDX_W;

  // Configuration and per-word accumulators.
  logic [MULT_W-1:0] mult_q;
  logic [IDX_W-1:0]  res_q, res_d;
  logic [KEY_W-1:0]  key_q, key_d;

  // Word-end pipeline.
  logic [IDX_W-1:0]  sidx_q;
  logic [KEY_W-1:0]  key_end_q;
  logic [MULT_W-1:0] frac_q;
  logic [IDX_W-1:0]  midx_q;
  logic              sum_vld_hit_q, mult_vld_hit_q;

  // Occupancy state.
  logic [TABLE_SIZE-1:0] sum_vld_q, mult_vld_q;
  logic [OCC_W-1:0]      sum_rdata, mult_rdata;
  logic [OCC_W-1:0]      sum_old, mult_old, sum_new, mult_new;
  logic [ADDR_W-1:0]     saddr, maddr;

  // Counters and held result.
  logic [TOT_W-1:0] sum_tot_q, mult_tot_q;
  logic [CNT_W-1:0] sum_empty_q, sum_single_q, sum_multi_q;
  logic [CNT_W-1:0] mult_empty_q, mult_single_q, mult_multi_q;
  logic [IDX_W-1:0] out_sidx_q, out_midx_q;
  logic             out_scoll_q, out_mcoll_q;

  logic [IDX_W-1:0]       byte_mod [BYTE_VALUES];
  logic [IDX_W:0]         res_sum;
  logic [2*KEY_W-1:0]     frac_prod;
  logic [PROD_W-1:0]      scale_prod;
  logic                   sum_hit, mult_hit;

  // Constant table of byte value modulo the table size.
  for (genvar g = 0; g < BYTE_VALUES; g++) begin : g_byte_mod
    assign byte_mod[g] = IDX_W'(g % TABLE_SIZE);
  end

  always_comb begin
    res_sum = {1'b0, res_q} + {1'b0, byte_mod[char_code_i]};
    if (res_sum >= {1'b0, TS_C}) begin
      res_sum = res_sum - {1'b0, TS_C};
    end
    res_d = res_sum[IDX_W-1:0];
    // Only the low 32 bits of the key reach the fraction.
    key_d = KEY_W'(key_q * POLY_BASE) + KEY_W'(char_code_i);
  end

  assign frac_prod  = key_end_q * mult_q;
  assign scale_prod = frac_q * TS_C;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mult_q <= MULT_RESET;
      res_q  <= '0;
      key_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        mult_q <= cfg_data_i;
      end
      if (cmd_i.acc_char) begin
        res_q <= res_d;
        key_q <= key_d;
      end else if (cmd_i.word_end) begin
        res_q <= '0;
        key_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.word_end) begin
      sidx_q    <= res_d;
      key_end_q <= key_d;
    end
    if (cmd_i.mul_en) begin
      frac_q <= frac_prod[MULT_W-1:0];
    end
    if (cmd_i.scale_en) begin
      midx_q <= scale_prod[PROD_W-1:MULT_W];
    end
    if (cmd_i.rd_en) begin
      sum_vld_hit_q  <= sum_vld_q[saddr];
      mult_vld_hit_q <= mult_vld_q[maddr];
    end
  end

  assign saddr = sidx_q[ADDR_W-1:0];
  assign maddr = midx_q[ADDR_W-1:0];

  dhbo_ram #(
    .WIDTH (OCC_W),
    .DEPTH (TABLE_SIZE)
  ) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (saddr),
    .wdata_i (sum_new),
    .re_i    (cmd_i.rd_en),
    .raddr_i (saddr),
    .rdata_o (sum_rdata)
  );

  dhbo_ram #(
    .WIDTH (OCC_W),
    .DEPTH (TABLE_SIZE)
  ) u_mult_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (maddr),
    .wdata_i (mult_new),
    .re_i    (cmd_i.rd_en),
    .raddr_i (maddr),
    .rdata_o (mult_rdata)
  );

  // A bucket never written since reset reads as empty.
  assign sum_old  = sum_vld_hit_q ? sum_rdata : OCC_EMPTY;
  assign mult_old = mult_vld_hit_q ? mult_rdata : OCC_EMPTY;
  assign sum_hit  = (sum_old != OCC_EMPTY);
  assign mult_hit = (mult_old != OCC_EMPTY);
  assign sum_new  = sum_hit ? OCC_MULTI : OCC_SINGLE;
  assign mult_new = mult_hit ? OCC_MULTI : OCC_SINGLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_vld_q     <= '0;
      mult_vld_q    <= '0;
      sum_tot_q     <= '0;
      mult_tot_q    <= '0;
      sum_empty_q   <= CNT_W'(TABLE_SIZE);
      sum_single_q  <= '0;
      sum_multi_q   <= '0;
      mult_empty_q  <= CNT_W'(TABLE_SIZE);
      mult_single_q <= '0;
      mult_multi_q  <= '0;
    end else if (cmd_i.wr_en) begin
      sum_vld_q[saddr]  <= 1'b1;
      mult_vld_q[maddr] <= 1'b1;
      if (sum_hit && (sum_tot_q != '1)) begin
        sum_tot_q <= sum_tot_q + TOT_W'(1);
      end
      if (mult_hit && (mult_tot_q != '1)) begin
        mult_tot_q <= mult_tot_q + TOT_W'(1);
      end
      if (sum_old == OCC_EMPTY) begin
        sum_empty_q  <= sum_empty_q - CNT_W'(1);
        sum_single_q <= sum_single_q + CNT_W'(1);
      end else if (sum_old == OCC_SINGLE) begin
        sum_single_q <= sum_single_q - CNT_W'(1);
        sum_multi_q  <= sum_multi_q + CNT_W'(1);
      end
      if (mult_old == OCC_EMPTY) begin
        mult_empty_q  <= mult_empty_q - CNT_W'(1);
        mult_single_q <= mult_single_q + CNT_W'(1);
      end else if (mult_old == OCC_SINGLE) begin
        mult_single_q <= mult_single_q - CNT_W'(1);
        mult_multi_q  <= mult_multi_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      out_sidx_q  <= sidx_q;
      out_midx_q  <= midx_q;
      out_scoll_q <= sum_hit;
      out_mcoll_q <= mult_hit;
    end
  end

  // Counters change only when a new result is loaded, so they double as
  // the result's totals.
  assign sum_index_o             = out_sidx_q;
  assign mult_index_o            = out_midx_q;
  assign sum_collision_o         = out_scoll_q;
  assign mult_collision_o        = out_mcoll_q;
  assign sum_collisions_total_o  = sum_tot_q;
  assign mult_collisions_total_o = mult_tot_q;
  assign sum_empty_o             = sum_empty_q;
  assign sum_single_o            = sum_single_q;
  assign sum_multi_o             = sum_multi_q;
  assign mult_empty_o            = mult_empty_q;
  assign mult_single_o           = mult_single_q;
  assign mult_multi_o            = mult_multi_q;

endmodule

/* rtl/dual_hash_bucket_occupancy.sv */
// Dual-hash bucket occupancy monitor.
// Words arrive on in_i one byte per transaction; last_char marks the final
// byte. Each word is hashed twice: a byte sum modulo TABLE_SIZE and a base-31
// polynomial key scaled by a 0.32 fixed-point multiplier (cfg_we_i and
// cfg_data_i write it; write only while the block is idle).
// Bytes that do not end a word are taken one per cycle while no word end
// is in progress, and give no result. A last byte starts the word-end
// sequence: fraction multiply, index scaling, table read and table update.
// The update step loads the result register that drives out_o, and in_i
// takes no byte until that step is done.
// The result carries both bucket indexes, collision flags, saturating
// collision totals and the empty/single/multi bucket counts of both tables.
// If out_o is stalled, the result waits in its register; the block still
// takes bytes and works down the next word end, holding it in the update
// step until the pending result is taken.
// Reset returns the multiplier to its default, clears the accumulators,
// marks every bucket empty through per-bucket valid bits, sets the empty
// counts to TABLE_SIZE and zeroes the rest; no clearing pass is needed.
`include "dual_hash_bucket_occupancy_defines.svh"

module dual_hash_bucket_occupancy import dhbo_pkg::*; #(
  parameter int TABLE_SIZE = 127
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [MULT_W-1:0] cfg_data_i,
  dhbo_in_if.sink           in_i,
  dhbo_out_if.source        out_o
);

  dhbo_cmd_t cmd;
  logic      in_ready;
  logic      out_valid;
  logic      sum_counts_ok;
  logic      mult_counts_ok;
  logic      word_end_acc;
  logic      idx_in_range;

  dhbo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_last_i   (in_i.last_char),
    .out_ready_i (out_o.ready),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .cmd_o       (cmd)
  );

  dhbo_datapath #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_datapath (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .cmd_i                   (cmd),
    .cfg_we_i                (cfg_we_i),
    .cfg_data_i              (cfg_data_i),
    .char_code_i             (in_i.char_code),
    .sum_index_o             (out_o.sum_index),
    .mult_index_o            (out_o.mult_index),
    .sum_collision_o         (out_o.sum_collision),
    .mult_collision_o        (out_o.mult_collision),
    .sum_collisions_total_o  (out_o.sum_collisions_total),
    .mult_collisions_total_o (out_o.mult_collisions_total),
    .sum_empty_o             (out_o.sum_empty),
    .sum_single_o            (out_o.sum_single),
    .sum_multi_o             (out_o.sum_multi),
    .mult_empty_o            (out_o.mult_empty),
    .mult_single_o           (out_o.mult_single),
    .mult_multi_o            (out_o.mult_multi)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

  // Every bucket is in exactly one of the three occupancy classes.
  assign sum_counts_ok  = ({2'b00, out_o.sum_empty} + {2'b00, out_o.sum_single}
                           + {2'b00, out_o.sum_multi}) == 9'(TABLE_SIZE);
  assign mult_counts_ok = ({2'b00, out_o.mult_empty} + {2'b00, out_o.mult_single}
                           + {2'b00, out_o.mult_multi}) == 9'(TABLE_SIZE);
  assign word_end_acc   = in_i.valid && in_ready && in_i.last_char;
  assign idx_in_range   = (out_o.sum_index < IDX_W'(TABLE_SIZE))
                          && (out_o.mult_index < IDX_W'(TABLE_SIZE));

  `DHBO_ASSERT_IMP(a_sum_counts, 1'b1, sum_counts_ok, "sum table bucket counts do not add up")
  `DHBO_ASSERT_IMP(a_mult_counts, 1'b1, mult_counts_ok, "mult table bucket counts do not add up")
  `DHBO_ASSERT_NXT(a_word_end_busy, word_end_acc, !in_ready, "input taken during word end")
  `DHBO_ASSERT_NXT(a_update_shows, cmd.wr_en, out_o.valid, "table update without a result")
  `DHBO_ASSERT_IMP(a_index_range, out_o.valid, idx_in_range, "bucket index out of range")

endmodule
